>>> hdl/sli_pkg.sv
`timescale 1ns / 1ps

package sli_pkg;

  // list geometry
  localparam int SLI_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 4;

  // operation kinds
  localparam logic [1:0] KIND_INSERT    = 2'd0;
  localparam logic [1:0] KIND_DELETE    = 2'd1;
  localparam logic [1:0] KIND_READ_ASC  = 2'd2;
  localparam logic [1:0] KIND_READ_DESC = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] data;
    logic [POS_W-1:0]          position;
    logic                      last;
  } out_item_t;

  // result of the shared compare unit: operand against stored entry
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

>>> hdl/sli_store.sv
`timescale 1ns / 1ps

module sli_store
  import sli_pkg::*;
#(
  parameter int CAPACITY = SLI_CAPACITY,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] rdata
);

  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // single registered read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sli_cmp.sv
`timescale 1ns / 1ps

module sli_cmp
  import sli_pkg::*;
(
  input  logic signed [VALUE_W-1:0] a,
  input  logic signed [VALUE_W-1:0] b,
  output cmp_res_t                  res
);

  // two's complement signed compare of operand against entry
  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

>>> hdl/sli_seq.sv
`timescale 1ns / 1ps

module sli_seq
  import sli_pkg::*;
#(
  parameter int CAPACITY = SLI_CAPACITY,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  // memory port
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic signed [VALUE_W-1:0] mem_wdata,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  logic signed [VALUE_W-1:0] mem_rdata,
  // shared compare unit
  output logic signed [VALUE_W-1:0] cmp_a,
  input  cmp_res_t                  cmp_res
);

  localparam int MAX_RD = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DONE   = 4'd1;
  localparam logic [3:0] S_INS_E0 = 4'd2;
  localparam logic [3:0] S_INS_EL = 4'd3;
  localparam logic [3:0] S_INS_SH = 4'd4;
  localparam logic [3:0] S_INS_WR = 4'd5;
  localparam logic [3:0] S_DEL_E0 = 4'd6;
  localparam logic [3:0] S_DEL_EL = 4'd7;
  localparam logic [3:0] S_DEL_SC = 4'd8;
  localparam logic [3:0] S_DEL_GO = 4'd9;
  localparam logic [3:0] S_DEL_SH = 4'd10;
  localparam logic [3:0] S_RD     = 4'd11;

  logic [3:0]                state_r, state_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [AW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             rem_r, rem_nxt;
  logic [1:0]                status_r, status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic          slot_free;
  logic          load;
  out_item_t     load_item;
  logic [CW-1:0] rd_cnt;
  logic          v_le_e;

  assign slot_free = !out_valid_r || out_ready;
  assign rd_cnt    = (count_r > CW'(MAX_RD)) ? CW'(MAX_RD) : count_r;
  assign v_le_e    = cmp_res.lt || cmp_res.eq;
  assign cmp_a     = val_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    load       = 1'b0;
    load_item  = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt   = in_data.kind;
          val_nxt    = in_data.value;
          pos_nxt    = '0;
          status_nxt = ST_OK;
          case (in_data.kind)
            KIND_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (count_r == '0) begin
                state_nxt = S_INS_WR;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_INS_E0;
              end
            end
            KIND_DELETE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_DEL_E0;
              end
            end
            default: begin
              // reads: empty list gives one status item with zero data
              if (count_r == '0) begin
                val_nxt    = '0;
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = (in_data.kind == KIND_READ_ASC) ? '0 : AW'(count_r - 1'b1);
                idx_nxt   = mem_raddr;
                rem_nxt   = rd_cnt;
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end

      // single result of insert, delete or a read of an empty list
      S_DONE: begin
        if (slot_free) begin
          load               = 1'b1;
          load_item.status   = status_r;
          load_item.data     = val_r;
          load_item.position = POS_W'(pos_r);
          load_item.last     = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      // insert: first entry in mem_rdata
      S_INS_E0: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(count_r - 1'b1);
        idx_nxt   = mem_raddr;
        state_nxt = v_le_e ? S_INS_SH : S_INS_EL;
      end

      // insert: last entry in mem_rdata
      S_INS_EL: begin
        if (!cmp_res.lt) begin
          pos_nxt   = AW'(count_r);
          state_nxt = S_INS_WR;
        end else begin
          state_nxt = S_INS_SH;
        end
      end

      // insert: walk down, moving entries not below the operand up one place
      S_INS_SH: begin
        if (v_le_e) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_r + 1'b1);
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_INS_WR;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(idx_r - 1'b1);
            idx_nxt   = mem_raddr;
          end
        end else begin
          pos_nxt   = AW'(idx_r + 1'b1);
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        count_nxt = CW'(count_r + 1'b1);
        state_nxt = S_DONE;
      end

      // delete: first entry in mem_rdata
      S_DEL_E0: begin
        if (cmp_res.eq) begin
          pos_nxt   = '0;
          state_nxt = S_DEL_GO;
        end else if (cmp_res.lt) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(count_r - 1'b1);
          state_nxt = S_DEL_EL;
        end
      end

      // delete: last entry in mem_rdata
      S_DEL_EL: begin
        if (cmp_res.eq) begin
          pos_nxt   = AW'(count_r - 1'b1);
          state_nxt = S_DEL_GO;
        end else if (!cmp_res.lt) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(1);
          idx_nxt   = mem_raddr;
          state_nxt = S_DEL_SC;
        end
      end

      // delete: scan up for the first entry not below the operand
      S_DEL_SC: begin
        if (!v_le_e) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_r + 1'b1);
          idx_nxt   = mem_raddr;
        end else if (cmp_res.eq) begin
          pos_nxt   = idx_r;
          state_nxt = S_DEL_GO;
        end else begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end
      end

      // delete: start closing the gap, nothing to move for the last entry
      S_DEL_GO: begin
        if (CW'(pos_r) + CW'(1) == count_r) begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(pos_r + 1'b1);
          idx_nxt   = pos_r;
          state_nxt = S_DEL_SH;
        end
      end

      // delete: entry idx+1 in mem_rdata moves down to idx
      S_DEL_SH: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (CW'(idx_r) + CW'(2) == count_r) begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_r + 2'd2);
          idx_nxt   = AW'(idx_r + 1'b1);
        end
      end

      // reads: one entry per cycle while the output slot drains
      S_RD: begin
        if (slot_free) begin
          load               = 1'b1;
          load_item.status   = ST_OK;
          load_item.data     = mem_rdata;
          load_item.position = POS_W'(idx_r);
          load_item.last     = (rem_r == CW'(1));
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rem_nxt   = CW'(rem_r - 1'b1);
            mem_re    = 1'b1;
            mem_raddr = (kind_r == KIND_READ_ASC) ? AW'(idx_r + 1'b1)
                                                  : AW'(idx_r - 1'b1);
            idx_nxt   = mem_raddr;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = load_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operands and result payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    rem_r      <= rem_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> hdl/sorted_list_insert_delete_unit.sv
// Insert and delete read stored entries over the single read port; a read passes its
// entries via the store read register and output register, one per cycle unless stalled.
// Throughput: one item at a time; the next item is taken when the last result is loaded.
// Timing is set by the single read port of the entry store and the one shared comparator.
// Reset (rst_n low, synchronous) empties the list and drops any pending result; the entry
// store itself is not cleared, only written entries are ever read.
`timescale 1ns / 1ps

module sorted_list_insert_delete_unit
  import sli_pkg::*;
#(
  parameter int CAPACITY = SLI_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic signed [VALUE_W-1:0] mem_rdata;
  logic signed [VALUE_W-1:0] cmp_a;
  cmp_res_t                  cmp_res;

  // sequencer and output register
  sli_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_a     (cmp_a),
    .cmp_res   (cmp_res)
  );

  // entry store
  sli_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shared comparator, operand against the entry just read
  sli_cmp u_cmp (
    .a   (cmp_a),
    .b   (mem_rdata),
    .res (cmp_res)
  );

endmodule

>>> hdl/sli_chk.sv
`timescale 1ns / 1ps

module sli_chk
  import sli_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted item always keeps ready low in the cycle after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting an item");

  // no new item while a read is still giving entries
  a_no_accept_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("ready in the middle of a read");

  // error statuses come as a single final result
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("error status on a non-final result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind sorted_list_insert_delete_unit sli_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sli_pkg::*;

  // directed stimulus row: typed expectation only where chk is set
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
    logic                      chk;
    logic [1:0]                st;
    logic signed [VALUE_W-1:0] dat;
    logic [POS_W-1:0]          pos;
  } dir_row_t;

  localparam int N_DIR  = 20;
  localparam int N_RAND = 460;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{KIND_READ_ASC,  32'sd0,        1'b1, ST_EMPTY,     32'sd0,        4'd0},
    '{KIND_READ_DESC, 32'sd12345,    1'b1, ST_EMPTY,     32'sd0,        4'd0},
    '{KIND_DELETE,    -32'sd5,       1'b1, ST_EMPTY,     -32'sd5,       4'd0},
    '{KIND_INSERT,    32'h7fffffff,  1'b1, ST_OK,        32'h7fffffff,  4'd0},
    '{KIND_INSERT,    32'h80000000,  1'b1, ST_OK,        32'h80000000,  4'd0},
    '{KIND_INSERT,    32'sd0,        1'b1, ST_OK,        32'sd0,        4'd1},
    '{KIND_INSERT,    32'sd0,        1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_INSERT,    -32'sd1,       1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_INSERT,    32'h7fffffff,  1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_DELETE,    32'sd12345,    1'b1, ST_NOT_FOUND, 32'sd12345,    4'd0},
    '{KIND_DELETE,    32'h80000001,  1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_READ_ASC,  32'sd0,        1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_READ_DESC, -32'sd1,       1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_DELETE,    32'sd0,        1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_DELETE,    32'h7fffffff,  1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_DELETE,    32'h80000000,  1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_INSERT,    32'h55555555,  1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_INSERT,    32'haaaaaaaa,  1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_READ_DESC, 32'sd0,        1'b0, ST_OK,        32'sd0,        4'd0},
    '{KIND_DELETE,    32'h7fffffff,  1'b0, ST_OK,        32'sd0,        4'd0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // shadow copy of the list
  logic signed [VALUE_W-1:0] shadow_vals [SLI_CAPACITY];
  int                        shadow_len = 0;

  out_item_t step_results [$];
  out_item_t pending_results [$];

  bit calm = 1'b0;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_ins = 0, n_del = 0, n_rd = 0;
  int n_full = 0, n_empty = 0, n_miss = 0;

  sorted_list_insert_delete_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic out_item_t mk_res(logic [1:0] st, logic signed [VALUE_W-1:0] d,
                                       int p, logic lst);
    out_item_t r;
    r.status   = st;
    r.data     = d;
    r.position = p[POS_W-1:0];
    r.last     = lst;
    return r;
  endfunction

  // apply one item to the shadow list and collect the results it gives
  function automatic void list_apply(input in_item_t it);
    logic signed [VALUE_W-1:0] v;
    int n, p, i, cnt, idx;
    bit hit;
    v = it.value;
    n = shadow_len;
    step_results.delete();
    case (it.kind)
      KIND_INSERT: begin
        if (n >= SLI_CAPACITY) begin
          step_results.push_back(mk_res(ST_FULL, v, 0, 1'b1));
        end else begin
          if (n == 0 || v <= shadow_vals[0]) begin
            p = 0;
          end else if (v >= shadow_vals[n-1]) begin
            p = n;
          end else begin
            p = 1;
            while (p < n && v > shadow_vals[p]) p++;
          end
          for (i = n; i > p; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[p] = v;
          shadow_len = n + 1;
          step_results.push_back(mk_res(ST_OK, v, p, 1'b1));
        end
      end
      KIND_DELETE: begin
        if (n == 0) begin
          step_results.push_back(mk_res(ST_EMPTY, v, 0, 1'b1));
        end else begin
          hit = 1'b0;
          p = 0;
          if (v == shadow_vals[0]) begin
            hit = 1'b1;
          end else if (v == shadow_vals[n-1]) begin
            p = n - 1;
            hit = 1'b1;
          end else if (v > shadow_vals[0] && v < shadow_vals[n-1]) begin
            p = 1;
            while (p < n && v > shadow_vals[p]) p++;
            if (p < n && shadow_vals[p] == v) hit = 1'b1;
          end
          if (!hit) begin
            step_results.push_back(mk_res(ST_NOT_FOUND, v, 0, 1'b1));
          end else begin
            for (i = p; i + 1 < n; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_len = n - 1;
            step_results.push_back(mk_res(ST_OK, v, p, 1'b1));
          end
        end
      end
      default: begin
        if (n == 0) begin
          step_results.push_back(mk_res(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          cnt = (n < MAX_RESULTS) ? n : MAX_RESULTS;
          for (i = 0; i < cnt; i++) begin
            idx = (it.kind == KIND_READ_ASC) ? i : (n - 1 - i);
            step_results.push_back(mk_res(ST_OK, shadow_vals[idx], idx, (i + 1 == cnt)));
          end
        end
      end
    endcase
  endfunction

  // present one item, wait for acceptance, then queue its expected results
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    list_apply(it);
    if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    // bookkeeping for the closing summary
    n_items++;
    case (it.kind)
      KIND_INSERT: n_ins++;
      KIND_DELETE: n_del++;
      default:     n_rd++;
    endcase
    case (step_results[0].status)
      ST_FULL:      n_full++;
      ST_EMPTY:     n_empty++;
      ST_NOT_FOUND: n_miss++;
      default: ;
    endcase
  endtask

  // operand choice: wide random, clustered small values, extremes or a stored entry
  function automatic logic signed [VALUE_W-1:0] pick_value(input bit want_stored);
    int sel;
    sel = $urandom_range(9);
    if (want_stored && shadow_len > 0 && sel < 7)
      return shadow_vals[$urandom_range(shadow_len - 1)];
    case (sel)
      0, 1, 2, 3: return $urandom;
      4, 5:       return $signed($urandom_range(8)) - 4;
      6: begin
        case ($urandom_range(3))
          0:       return 32'h80000000;
          1:       return 32'h7fffffff;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        if (shadow_len > 0) return shadow_vals[$urandom_range(shadow_len - 1)];
        return $urandom;
      end
    endcase
  endfunction

  // result side: random back-pressure and checking against the oldest expectation
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 36);
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item status=%0d data=%0d position=%0d last=%0d",
                 $time, out_data.status, out_data.data, out_data.position, out_data.last);
        errors++;
      end else begin
        automatic out_item_t e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
        if (out_data.data !== e.data) begin
          $display("%0t: data expected %0d actual %0d", $time, e.data, out_data.data);
          errors++;
        end
        if (out_data.position !== e.position) begin
          $display("%0t: position expected %0d actual %0d", $time, e.position,
                   out_data.position);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    in_item_t  it;
    out_item_t tr;
    int        mode, burst, r, k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int d = 0; d < N_DIR; d++) begin
      it.kind  = DIR_ROWS[d].kind;
      it.value = DIR_ROWS[d].value;
      tr = mk_res(DIR_ROWS[d].st, DIR_ROWS[d].dat, DIR_ROWS[d].pos, 1'b1);
      send_item(it, DIR_ROWS[d].chk, tr);
    end

    // random bursts: grow toward full, shrink toward empty, or mixed
    k = 0;
    mode = 0;
    burst = 0;
    tr = '0;
    while (k < N_RAND) begin
      if (burst == 0) begin
        mode  = $urandom_range(2);
        burst = $urandom_range(20, 45);
      end
      calm = (k >= 200 && k < 290);
      r = $urandom_range(99);
      case (mode)
        0:       it.kind = (r < 70) ? KIND_INSERT : (r < 85) ? KIND_DELETE : KIND_READ_ASC;
        1:       it.kind = (r < 70) ? KIND_DELETE : (r < 85) ? KIND_INSERT : KIND_READ_ASC;
        default: it.kind = (r < 40) ? KIND_INSERT : (r < 75) ? KIND_DELETE : KIND_READ_ASC;
      endcase
      if (it.kind == KIND_READ_ASC && $urandom_range(1) == 1) it.kind = KIND_READ_DESC;
      it.value = (it.kind == KIND_DELETE) ? pick_value(1'b1) : pick_value(1'b0);
      send_item(it, 1'b0, tr);
      burst--;
      k++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain and let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("ran %0d items (%0d inserts, %0d deletes, %0d reads), %0d results checked",
             n_items, n_ins, n_del, n_rd, n_results);
    $display("full-list refusals %0d, empty-list results %0d, values not found %0d",
             n_full, n_empty, n_miss);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
